// ===== hdl/lpht_pkg.sv =====
// Shared types and constants for the linear probe hash table.
package lpht_pkg;

  localparam logic [1:0] MARK_EMPTY = 2'd0;
  localparam logic [1:0] MARK_LIVE  = 2'd1;
  localparam logic [1:0] MARK_TOMB  = 2'd2;

  localparam logic [1:0] KIND_LOOKUP = 2'd0;
  localparam logic [1:0] KIND_INSERT = 2'd1;
  localparam logic [1:0] KIND_DELETE = 2'd2;

  localparam logic [1:0] STAT_DONE     = 2'd0;
  localparam logic [1:0] STAT_NOTFOUND = 2'd1;
  localparam logic [1:0] STAT_FULL     = 2'd2;

  localparam logic [1:0] REG_CAPACITY = 2'd0;
  localparam logic [1:0] REG_LOAD     = 2'd1;
  localparam logic [1:0] REG_TAG      = 2'd2;

  localparam logic [3:0] CAPACITY_RESET = 4'd10;
  localparam logic [6:0] LOAD_RESET     = 7'd70;
  localparam logic [6:0] PERCENT_SCALE  = 7'd100;

  // Low bits of the 64-bit FNV prime; its 2^40 term never reaches the slot index.
  localparam logic [8:0] FNV_LOW = 9'h1B3;

  localparam logic [2:0] HASH_LAST = 3'd6;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_HASH, ST_START, ST_READ, ST_EVAL, ST_COMMIT
  } state_t;

  typedef struct packed {
    logic       clear;
    logic       load;
    logic       hash;
    logic [2:0] hash_step;
    logic       start;
    logic       read;
    logic       eval;
    logic       commit;
  } cmd_t;

  typedef struct packed {
    logic clear_done;
    logic probe_end;
  } dp_status_t;

endpackage

// ===== hdl/lpht_ram.sv =====
// Generic single-port-write, registered-read RAM.
module lpht_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hdl/lpht_datapath.sv =====
// Datapath: hash unit, probe registers, slot memories and result register.
module lpht_datapath #(
  parameter int SLOTS_LOG2 = 10
) (
  input  logic                clk,
  input  logic                rst,
  input  lpht_pkg::cmd_t      cmd,
  output lpht_pkg::dp_status_t stat,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [7:0]          cfg_data,
  input  logic [1:0]          in_kind,
  input  logic [63:0]         in_key,
  input  logic [63:0]         in_value,
  output logic [1:0]          out_status,
  output logic [63:0]         out_found,
  output logic [10:0]         out_live
);
  import lpht_pkg::*;

  localparam int AW  = SLOTS_LOG2;
  localparam int CW  = SLOTS_LOG2 + 1;
  localparam int LW  = (7 + SLOTS_LOG2 > 18) ? 7 + SLOTS_LOG2 + 1 : 19;
  localparam logic [4:0] LG_MAX = 5'(SLOTS_LOG2);

  logic [3:0]    capacity_log2;
  logic [6:0]    load_percent;
  logic [7:0]    key_tag;
  logic [1:0]    kind;
  logic [63:0]   key;
  logic [63:0]   value;
  logic [63:0]   hval;
  logic [AW-1:0] idx;
  logic [CW-1:0] n;
  logic          have_free;
  logic [AW-1:0] free_idx;
  logic          hit;
  logic [63:0]   found;
  logic [10:0]   total;
  logic [AW-1:0] clr_addr;

  logic [4:0]    lg;
  logic [AW-1:0] mask;
  logic [CW-1:0] cap;
  logic [AW-1:0] tag_word;
  logic [AW+8:0] prod;
  logic [63:0]   hstep;
  logic [1:0]    mark_q;
  logic [63:0]   key_q;
  logic [63:0]   val_q;
  logic          hit_now;
  logic          over_load;
  logic [LW-1:0] used_scaled;
  logic [LW-1:0] limit_scaled;

  logic          mark_we;
  logic [AW-1:0] mark_wa;
  logic [1:0]    mark_wd;
  logic          key_we;
  logic          val_we;
  logic [AW-1:0] kv_wa;

  logic [1:0]    status_next;
  logic [63:0]   found_next;
  logic [10:0]   total_next;

  always_comb begin
    lg = {1'b0, capacity_log2};
    if (lg < 5'd1) begin
      lg = 5'd1;
    end
    if (lg > LG_MAX) begin
      lg = LG_MAX;
    end
    mask = {AW{1'b1}} >> (LG_MAX - lg);
    cap  = CW'(1) << lg;
  end

  always_comb begin
    unique case (cmd.hash_step)
      3'd0:    hstep = ~hval + (hval << 21);
      3'd1:    hstep = hval ^ (hval >> 24);
      3'd2:    hstep = hval + (hval << 3) + (hval << 8);
      3'd3:    hstep = hval ^ (hval >> 14);
      3'd4:    hstep = hval + (hval << 2) + (hval << 4);
      3'd5:    hstep = hval ^ (hval >> 28);
      default: hstep = hval + (hval << 31);
    endcase
  end

  assign tag_word = hval[AW-1:0] ^ AW'({56'd0, key_tag});
  assign prod     = {9'd0, tag_word} * {{AW{1'b0}}, FNV_LOW};

  assign hit_now = (mark_q == MARK_LIVE) && (key_q == key);
  assign stat.probe_end = cmd.eval &&
    (hit_now || mark_q == MARK_EMPTY || (n + CW'(1)) == cap);
  assign stat.clear_done = cmd.clear && (clr_addr == {AW{1'b1}});

  assign used_scaled  = LW'(total) * LW'(PERCENT_SCALE);
  assign limit_scaled = LW'(load_percent) << lg;
  assign over_load    = used_scaled >= limit_scaled;

  always_comb begin
    status_next = STAT_NOTFOUND;
    found_next  = '0;
    total_next  = total;
    mark_we     = 1'b0;
    mark_wa     = idx;
    mark_wd     = MARK_TOMB;
    key_we      = 1'b0;
    val_we      = 1'b0;
    kv_wa       = idx;
    if (cmd.clear) begin
      mark_we = 1'b1;
      mark_wa = clr_addr;
      mark_wd = MARK_EMPTY;
    end else if (cmd.commit) begin
      unique case (kind)
        KIND_LOOKUP: begin
          if (hit) begin
            status_next = STAT_DONE;
            found_next  = found;
          end
        end
        KIND_INSERT: begin
          if (hit) begin
            status_next = STAT_DONE;
            val_we      = 1'b1;
          end else if (over_load || !have_free) begin
            status_next = STAT_FULL;
          end else begin
            status_next = STAT_DONE;
            key_we      = 1'b1;
            val_we      = 1'b1;
            kv_wa       = free_idx;
            mark_we     = 1'b1;
            mark_wa     = free_idx;
            mark_wd     = MARK_LIVE;
            total_next  = total + 11'd1;
          end
        end
        KIND_DELETE: begin
          if (hit) begin
            status_next = STAT_DONE;
            mark_we     = 1'b1;
            if (total != 11'd0) begin
              total_next = total - 11'd1;
            end
          end
        end
        default: begin
          status_next = STAT_NOTFOUND;
        end
      endcase
    end
  end

  lpht_ram #(.WIDTH(2), .DEPTH(1 << SLOTS_LOG2)) u_mark_ram (
    .clk(clk), .wr_en(mark_we), .wr_addr(mark_wa), .wr_data(mark_wd),
    .rd_en(cmd.read), .rd_addr(idx), .rd_data(mark_q)
  );

  lpht_ram #(.WIDTH(64), .DEPTH(1 << SLOTS_LOG2)) u_key_ram (
    .clk(clk), .wr_en(key_we), .wr_addr(kv_wa), .wr_data(key),
    .rd_en(cmd.read), .rd_addr(idx), .rd_data(key_q)
  );

  lpht_ram #(.WIDTH(64), .DEPTH(1 << SLOTS_LOG2)) u_val_ram (
    .clk(clk), .wr_en(val_we), .wr_addr(kv_wa), .wr_data(value),
    .rd_en(cmd.read), .rd_addr(idx), .rd_data(val_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity_log2 <= CAPACITY_RESET;
      load_percent  <= LOAD_RESET;
      key_tag       <= '0;
      total         <= '0;
      clr_addr      <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_CAPACITY: capacity_log2 <= cfg_data[3:0];
          REG_LOAD:     load_percent  <= cfg_data[6:0];
          REG_TAG:      key_tag       <= cfg_data;
          default:      ;
        endcase
      end
      if (cmd.clear) begin
        clr_addr <= clr_addr + AW'(1);
      end
      if (cmd.commit) begin
        total <= total_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind  <= in_kind;
      key   <= in_key;
      value <= in_value;
      hval  <= in_key;
    end
    if (cmd.hash) begin
      hval <= hstep;
    end
    if (cmd.start) begin
      idx       <= prod[AW-1:0] & mask;
      n         <= '0;
      have_free <= 1'b0;
      hit       <= 1'b0;
    end
    if (cmd.eval) begin
      if ((mark_q != MARK_LIVE) && !have_free) begin
        have_free <= 1'b1;
        free_idx  <= idx;
      end
      if (hit_now) begin
        hit   <= 1'b1;
        found <= val_q;
      end else begin
        idx <= (idx + AW'(1)) & mask;
      end
      n <= n + CW'(1);
    end
    if (cmd.commit) begin
      out_status <= status_next;
      out_found  <= found_next;
      out_live   <= total_next;
    end
  end

endmodule

// ===== hdl/lpht_ctrl.sv =====
// Controller state machine sequencing clear, hash, probe and commit.
module lpht_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  lpht_pkg::dp_status_t stat,
  output lpht_pkg::cmd_t       cmd
);
  import lpht_pkg::*;

  state_t     state;
  state_t     state_next;
  logic [2:0] step;
  logic [2:0] step_next;
  logic       out_valid_next;
  logic       out_free;

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      step      <= step_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    step_next      = step;
    cmd            = '0;
    in_ready       = 1'b0;
    out_valid_next = out_valid && !out_ready;
    unique case (state)
      ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (stat.clear_done) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          step_next  = '0;
          state_next = ST_HASH;
        end
      end
      ST_HASH: begin
        cmd.hash      = 1'b1;
        cmd.hash_step = step;
        step_next     = step + 3'd1;
        if (step == HASH_LAST) begin
          state_next = ST_START;
        end
      end
      ST_START: begin
        cmd.start  = 1'b1;
        state_next = ST_READ;
      end
      ST_READ: begin
        cmd.read   = 1'b1;
        state_next = ST_EVAL;
      end
      ST_EVAL: begin
        cmd.eval   = 1'b1;
        state_next = stat.probe_end ? ST_COMMIT : ST_READ;
      end
      ST_COMMIT: begin
        if (out_free) begin
          cmd.commit     = 1'b1;
          out_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== hdl/linear_probe_hash_table_core.sv =====
// Top level of the linear probe hash table: controller plus datapath.
//  Channel  Signals                          Beat contents
//  s_       s_tvalid s_tready s_tdata s_tuser  key, value; kind in tuser
//  m_       m_tvalid m_tready m_tdata m_tuser  found_value, live_count; status
//  cfg_     cfg_valid cfg_ready cfg_index cfg_data  register write
// An operation runs the seven-step hash chain, then reads and evaluates the probed slots
// in turn through the registered read of the slot memories, and commits once output is free.
// After reset a clearing pass marks every slot empty, with s_tready low.
// A result waits in the output register; the next beat is taken while it waits.
module linear_probe_hash_table_core #(
  parameter int SLOTS_LOG2 = 10
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [127:0]  s_tdata,   // key[63:0], value[127:64]
  input  logic [1:0]    s_tuser,   // kind[1:0]
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [79:0]   m_tdata,   // found_value[63:0], live_count[74:64], zero fill
  output logic [1:0]    m_tuser,   // status[1:0]
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [1:0]    cfg_index,
  input  logic [7:0]    cfg_data
);
  import lpht_pkg::*;

  cmd_t       cmd;
  dp_status_t stat;
  logic [63:0] found_value;
  logic [10:0] live_count;

  assign cfg_ready = 1'b1;

  lpht_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(s_tvalid), .in_ready(s_tready),
    .out_valid(m_tvalid), .out_ready(m_tready),
    .stat(stat), .cmd(cmd)
  );

  lpht_datapath #(.SLOTS_LOG2(SLOTS_LOG2)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat),
    .cfg_we(cfg_valid && cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_kind(s_tuser), .in_key(s_tdata[63:0]), .in_value(s_tdata[127:64]),
    .out_status(m_tuser), .out_found(found_value), .out_live(live_count)
  );

  assign m_tdata = {5'd0, live_count, found_value};

endmodule

// ===== hdl/lpht_checker.sv =====
// Port-level checker for the hash table core, bound to the top level.
module lpht_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [79:0]  m_tdata,
  input logic [1:0]   m_tuser
);
  import lpht_pkg::*;

  a_reset_quiet: assert property (@(posedge clk) rst |=> !m_tvalid && !s_tready)
    else $error("Core not quiet after reset.");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("Core took a second beat while busy.");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser == STAT_DONE || m_tuser == STAT_NOTFOUND ||
                  m_tuser == STAT_FULL))
    else $error("Undefined status code.");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("Result changed while stalled.");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser != STAT_DONE) |-> (m_tdata[63:0] == 64'd0))
    else $error("Nonzero value on a failed operation.");

endmodule

bind linear_probe_hash_table_core lpht_checker u_lpht_checker (
  .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
);
